// ===== rtl/spt_pkg.sv =====
// shared input width constant for the strong pseudoprime test block
`default_nettype none
package spt_pkg;
   localparam int IN_WIDTH = 32;
endpackage
`default_nettype wire

// ===== rtl/spt_front.sv =====
// input stage: accepts items, masks fields and screens trivial candidates
`default_nettype none
module spt_front import spt_pkg::*; #(
   parameter int NUM_WIDTH = 32
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_push,
   output logic                      req_full,
   input  wire logic [IN_WIDTH-1:0]  req_candidate,
   input  wire logic [IN_WIDTH-1:0]  req_base,
   output logic                      q_valid,
   input  wire logic                 q_take,
   output logic [NUM_WIDTH-1:0]      q_n,
   output logic [NUM_WIDTH-1:0]      q_b,
   output logic                      q_trivial
);
   // two-entry queue between front and back
   logic [1:0]           valid_ff, valid_in;
   logic [NUM_WIDTH-1:0] n_ff [2];
   logic [NUM_WIDTH-1:0] b_ff [2];
   logic [1:0]           triv_ff;
   logic                 wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [NUM_WIDTH-1:0] n_m, b_m;
   logic                 push_ok, take_ok;

   always_comb begin
      n_m = NUM_WIDTH'(64'(req_candidate) & ((64'd1 << NUM_WIDTH) - 64'd1));
      b_m = NUM_WIDTH'(64'(req_base) & ((64'd1 << NUM_WIDTH) - 64'd1));
   end

   assign req_full  = valid_ff[wr_ptr_ff];
   assign push_ok   = req_push && !req_full;
   assign q_valid   = valid_ff[rd_ptr_ff];
   assign take_ok   = q_take && q_valid;
   assign q_n       = n_ff[rd_ptr_ff];
   assign q_b       = b_ff[rd_ptr_ff];
   assign q_trivial = triv_ff[rd_ptr_ff];

   always_comb begin
      valid_in  = valid_ff;
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (take_ok) begin
         valid_in[rd_ptr_ff] = 1'b0;
         rd_ptr_in = !rd_ptr_ff;
      end
      if (push_ok) begin
         valid_in[wr_ptr_ff] = 1'b1;
         wr_ptr_in = !wr_ptr_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= '0;
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
      end else begin
         valid_ff  <= valid_in;
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
      end
      if (push_ok) begin
         n_ff[wr_ptr_ff]    <= n_m;
         b_ff[wr_ptr_ff]    <= b_m;
         triv_ff[wr_ptr_ff] <= (n_m < NUM_WIDTH'(2));
      end
   end
endmodule
`default_nettype wire

// ===== rtl/spt_back.sv =====
// execution stage: base reduction, modular exponentiations and the verdict
`default_nettype none
module spt_back #(
   parameter int NUM_WIDTH = 32
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 q_valid,
   output logic                      q_take,
   input  wire logic [NUM_WIDTH-1:0] q_n,
   input  wire logic [NUM_WIDTH-1:0] q_b,
   input  wire logic                 q_trivial,
   output logic                      rsp_empty,
   input  wire logic                 rsp_pop,
   output logic                      rsp_passes
);
   localparam int CW = $clog2(NUM_WIDTH + 1);
   localparam int W1 = NUM_WIDTH + 1;

   typedef enum logic [3:0] {
      S_IDLE, S_RED, S_PSTART, S_PSTEP, S_MSTEP, S_PNEXT, S_CHECK, S_DONE
   } state_type;

   state_type            state_ff;
   logic [NUM_WIDTH-1:0] n_ff, b_ff, k_ff, e_ff, acc_ff, sq_ff;
   logic [NUM_WIDTH-1:0] ma_ff, mb_ff, macc_ff;
   logic                 msel_ff;     // 0: acc*sq, 1: sq*sq
   logic                 first_ff;
   logic [W1-1:0]        rem_ff;
   logic [CW-1:0]        cnt_ff;
   logic                 pass_ff, out_valid_ff;

   // one restoring division step and one add-mod step
   logic [W1-1:0]        rem_sh;
   logic [NUM_WIDTH-1:0] gap_b, sum_acc, sum_add;
   always_comb begin
      rem_sh  = {rem_ff[NUM_WIDTH-1:0], b_ff[NUM_WIDTH-1]};
      gap_b   = n_ff - ma_ff;
      sum_acc = (macc_ff >= gap_b) ? macc_ff - gap_b : macc_ff + ma_ff;
      sum_add = (ma_ff >= gap_b) ? ma_ff - gap_b : ma_ff + ma_ff;
   end

   assign q_take     = (state_ff == S_IDLE) && q_valid && !out_valid_ff;
   assign rsp_empty  = !out_valid_ff;
   assign rsp_passes = pass_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         if (rsp_pop && out_valid_ff) out_valid_ff <= 1'b0;
         unique case (state_ff)
            S_IDLE: begin
               if (q_take) begin
                  n_ff   <= q_n;
                  b_ff   <= q_b;
                  rem_ff <= '0;
                  cnt_ff <= CW'(NUM_WIDTH);
                  if (q_trivial) begin
                     pass_ff  <= 1'b0;
                     state_ff <= S_DONE;
                  end else state_ff <= S_RED;
               end
            end
            S_RED: begin
               // b mod n, one quotient bit a cycle
               b_ff <= {b_ff[NUM_WIDTH-2:0], 1'b0};
               if (rem_sh >= W1'(n_ff)) rem_ff <= rem_sh - W1'(n_ff);
               else rem_ff <= rem_sh;
               cnt_ff <= cnt_ff - CW'(1);
               if (cnt_ff == CW'(1)) begin
                  k_ff     <= n_ff - NUM_WIDTH'(1);
                  first_ff <= 1'b1;
                  state_ff <= S_PSTART;
               end
            end
            S_PSTART: begin
               if (first_ff && cnt_ff == '0) b_ff <= rem_ff[NUM_WIDTH-1:0];
               e_ff     <= k_ff;
               acc_ff   <= NUM_WIDTH'(1);
               sq_ff    <= (first_ff && cnt_ff == '0) ? rem_ff[NUM_WIDTH-1:0] : b_ff;
               state_ff <= S_PSTEP;
               cnt_ff   <= CW'(1);
            end
            S_PSTEP: begin
               if (e_ff == '0) state_ff <= S_CHECK;
               else begin
                  msel_ff <= !e_ff[0];
                  ma_ff   <= e_ff[0] ? acc_ff : sq_ff;
                  mb_ff   <= sq_ff;
                  macc_ff <= '0;
                  state_ff <= S_MSTEP;
               end
            end
            S_MSTEP: begin
               if (mb_ff[0]) macc_ff <= sum_acc;
               ma_ff <= sum_add;
               mb_ff <= mb_ff >> 1;
               if (mb_ff == '0) begin
                  if (!msel_ff) begin
                     acc_ff  <= macc_ff;
                     msel_ff <= 1'b1;
                     ma_ff   <= sq_ff;
                     mb_ff   <= sq_ff;
                     macc_ff <= '0;
                  end else begin
                     sq_ff    <= macc_ff;
                     e_ff     <= e_ff >> 1;
                     state_ff <= S_PSTEP;
                  end
               end
            end
            S_CHECK: begin
               if (first_ff) begin
                  first_ff <= 1'b0;
                  if (acc_ff != NUM_WIDTH'(1)) begin
                     pass_ff  <= 1'b0;
                     state_ff <= S_DONE;
                  end else state_ff <= S_PNEXT;
               end else state_ff <= S_PNEXT;
            end
            S_PNEXT: begin
               if (!k_ff[0] && acc_ff == NUM_WIDTH'(1)) begin
                  k_ff     <= k_ff >> 1;
                  state_ff <= S_PSTART;
               end else begin
                  pass_ff  <= (acc_ff == NUM_WIDTH'(1)) ||
                              (acc_ff == n_ff - NUM_WIDTH'(1));
                  state_ff <= S_DONE;
               end
            end
            S_DONE: begin
               out_valid_ff <= 1'b1;
               state_ff     <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end
endmodule
`default_nettype wire

// ===== rtl/strong_pseudoprime_test_top.sv =====
// top level of the strong pseudoprime test block
// candidates below two skip the base reduction and the exponentiations and fail;
// the exponentiations run on a bit-serial modular multiplier
// one item is worked on at a time; a two-entry queue lets new items wait meanwhile
// the back stage takes a new item only when idle and its last result has been popped
// reset is synchronous, active high, and empties the queue and the result stage
`default_nettype none
module strong_pseudoprime_test_top import spt_pkg::*; #(
   parameter int NUM_WIDTH = 32
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_push,
   output logic                     req_full,
   input  wire logic [IN_WIDTH-1:0] req_candidate,
   input  wire logic [IN_WIDTH-1:0] req_base,
   output logic                     rsp_empty,
   input  wire logic                rsp_pop,
   output logic                     rsp_passes
);
   // queue handshake between front and back
   logic                 q_valid, q_take, q_trivial;
   logic [NUM_WIDTH-1:0] q_n, q_b;

   // front: mask fields, flag candidates below two
   spt_front #(.NUM_WIDTH(NUM_WIDTH)) u_front (
      .clock, .reset, .req_push, .req_full, .req_candidate, .req_base,
      .q_valid, .q_take, .q_n, .q_b, .q_trivial
   );

   // back: reduce base, run exponentiations, hold the verdict
   spt_back #(.NUM_WIDTH(NUM_WIDTH)) u_back (
      .clock, .reset, .q_valid, .q_take, .q_n, .q_b, .q_trivial,
      .rsp_empty, .rsp_pop, .rsp_passes
   );

`ifndef ASSERT_OFF
   // a result never appears while the queue hands over an item
   a_take_no_result: assert property (@(posedge clock) disable iff (reset)
      q_take |-> rsp_empty) else $error("item taken while result pending");
   // a held result stays until popped
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=> (!rsp_empty && $stable(rsp_passes)))
      else $error("result lost");
`endif
endmodule
`default_nettype wire

// ===== tb/strong_pseudoprime_test_top_tb.sv =====
// self-checking testbench for the strong pseudoprime test block
`default_nettype none
module strong_pseudoprime_test_top_tb import spt_pkg::*; ();

   localparam int NUM_WIDTH = 32;
   localparam int DRAIN_CYCLES = 80000;   // worst case: one exponentiation per exponent bit
   localparam int RANDOM_ITEMS = 270;

   typedef struct {
      logic [IN_WIDTH-1:0] candidate;
      logic [IN_WIDTH-1:0] base;
      bit                  known;      // verdict typed in below
      bit                  verdict;
   } test_row_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_push = 1'b0;
   logic                req_full;
   logic [IN_WIDTH-1:0] req_candidate = '0;
   logic [IN_WIDTH-1:0] req_base = '0;
   logic                rsp_empty;
   logic                rsp_pop = 1'b0;
   logic                rsp_passes;

   bit pending_verdicts[$];   // verdicts still owed by the block, oldest first
   int mismatch_count = 0;
   int checked_count = 0;

   // a few primes, some with long runs of trailing zeros in n-1
   logic [31:0] prime_pool[8] = '{32'd4294967291, 32'd2147483647, 32'd65537, 32'd1000003,
                                  32'd998244353, 32'd257, 32'd97, 32'd3221225473};

   // directed rows: verdicts typed in only where they are obvious
   test_row_type directed_rows[] = '{
      '{32'd0,          32'd0,          1'b1, 1'b0},   // candidate zero
      '{32'd0,          32'hffff_ffff,  1'b1, 1'b0},
      '{32'd1,          32'd5,          1'b1, 1'b0},   // candidate one
      '{32'd1,          32'hffff_ffff,  1'b1, 1'b0},
      '{32'd2,          32'd3,          1'b1, 1'b1},   // candidate two, odd base
      '{32'd2,          32'hffff_ffff,  1'b1, 1'b1},
      '{32'd2,          32'd4,          1'b1, 1'b0},   // candidate two, even base
      '{32'd2,          32'd0,          1'b1, 1'b0},
      '{32'd7,          32'd14,         1'b1, 1'b0},   // base a multiple of n
      '{32'hffff_ffff,  32'hffff_ffff,  1'b1, 1'b0},
      '{32'd13,         32'd0,          1'b1, 1'b0},   // zero base
      '{32'd13,         32'd1,          1'b1, 1'b1},   // base one always passes
      '{32'd9,          32'd8,          1'b0, 1'b0},   // base n-1
      '{32'd3,          32'd2,          1'b0, 1'b0},
      '{32'd2047,       32'd2,          1'b0, 1'b0},   // strong liar to base two
      '{32'd561,        32'd2,          1'b0, 1'b0},   // carmichael number
      '{32'd65537,      32'd3,          1'b0, 1'b0},
      '{32'd4294967291, 32'd2,          1'b0, 1'b0},   // largest 32-bit prime
      '{32'd4294967291, 32'hffff_fffe,  1'b0, 1'b0},
      '{32'hffff_ffff,  32'd2,          1'b0, 1'b0},
      '{32'hffff_fffe,  32'h5555_5555,  1'b0, 1'b0},
      '{32'd998244353,  32'd3,          1'b0, 1'b0},   // n-1 has 23 factors of two
      '{32'h8000_0000,  32'haaaa_aaaa,  1'b0, 1'b0}
   };

   strong_pseudoprime_test_top #(.NUM_WIDTH(NUM_WIDTH)) u_dut (
      .clock         (clock),
      .reset         (reset),
      .req_push      (req_push),
      .req_full      (req_full),
      .req_candidate (req_candidate),
      .req_base      (req_base),
      .rsp_empty     (rsp_empty),
      .rsp_pop       (rsp_pop),
      .rsp_passes    (rsp_passes)
   );

   always #6 clock = ~clock;

   // exact modular product, operands below m < 2^32 so 64 bits suffice
   function automatic longint unsigned mod_product(longint unsigned a, longint unsigned b,
                                                   longint unsigned m);
      return (a * b) % m;
   endfunction

   function automatic longint unsigned mod_power(longint unsigned b, longint unsigned e,
                                                 longint unsigned m);
      longint unsigned acc;
      longint unsigned sq;
      acc = 1;
      sq = b;
      while (e != 0) begin
         if (e[0])
            acc = mod_product(acc, sq, m);
         sq = mod_product(sq, sq, m);
         e = e >> 1;
      end
      return acc;
   endfunction

   // strong probable prime verdict for candidate n and base b
   function automatic bit strong_verdict(logic [IN_WIDTH-1:0] cand, logic [IN_WIDTH-1:0] wit);
      longint unsigned n;
      longint unsigned b;
      longint unsigned k;
      longint unsigned r;
      n = cand;
      b = wit;
      if (n < 2)
         return 1'b0;
      b = b % n;
      k = n - 1;
      r = mod_power(b, k, n);
      if (r != 1)
         return 1'b0;
      while (!k[0] && r == 1) begin
         k = k >> 1;
         r = mod_power(b, k, n);
      end
      return (r == 1) || (r == n - 1);
   endfunction

   task automatic report_mismatch(string what);
      $display("mismatch at %0t: %s", $time, what);
      mismatch_count++;
   endtask

   // present one item and hold it until the queue takes it
   task automatic push_item(logic [IN_WIDTH-1:0] cand, logic [IN_WIDTH-1:0] wit,
                            bit known, bit verdict);
      req_push <= 1'b1;
      req_candidate <= cand;
      req_base <= wit;
      @(posedge clock);
      while (req_full)
         @(posedge clock);
      // accepted at this edge
      pending_verdicts.push_back(known ? verdict : strong_verdict(cand, wit));
   endtask

   // gap after a burst; a long gap now and then lands mid-computation
   int burst_left = 0;
   task automatic maybe_idle();
      int gap;
      if (burst_left > 0) begin
         burst_left--;
         return;
      end
      burst_left = $urandom_range(0, 7);
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 4000) : $urandom_range(0, 20);
      if (gap != 0) begin
         req_push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // receiver: long stretches with no stall, otherwise random short and long stalls
   int stall_hold = 0;
   int cycle_count = 0;
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count[13]) begin
         rsp_pop <= 1'b1;
      end else if (stall_hold > 0) begin
         stall_hold <= stall_hold - 1;
         rsp_pop <= 1'b0;
      end else if ($urandom_range(0, 29) == 0) begin
         stall_hold <= $urandom_range(1, 300);
         rsp_pop <= 1'b0;
      end else begin
         rsp_pop <= ($urandom_range(0, 3) != 0);
      end
   end

   // result checker, compares against the oldest owed verdict
   always @(posedge clock) begin
      if (!reset && rsp_pop && !rsp_empty) begin
         if (pending_verdicts.size() == 0) begin
            report_mismatch("result with nothing owed");
         end else begin
            bit want;
            want = pending_verdicts.pop_front();
            checked_count++;
            if (rsp_passes !== want)
               report_mismatch($sformatf("passes %b, wanted %b (result %0d)",
                                         rsp_passes, want, checked_count));
         end
      end
   end

   initial begin
      logic [IN_WIDTH-1:0] cand;
      logic [IN_WIDTH-1:0] wit;
      int pick;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         push_item(directed_rows[i].candidate, directed_rows[i].base,
                   directed_rows[i].known, directed_rows[i].verdict);
         maybe_idle();
      end

      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         pick = $urandom_range(0, 9);
         wit = $urandom();
         if (pick < 3) begin
            // primes: the deep halving path
            cand = prime_pool[$urandom_range(0, 7)];
         end else if (pick < 6) begin
            cand = $urandom_range(0, 2000);
            if ($urandom_range(0, 1) == 0)
               wit = $urandom_range(0, 2000);
         end else if (pick < 9) begin
            cand = $urandom();
         end else begin
            // base a multiple of n, or n-1
            cand = $urandom_range(2, 100000);
            wit = ($urandom_range(0, 1) == 0) ? cand * $urandom_range(0, 40000) : cand - 1;
         end
         push_item(cand, wit, 1'b0, 1'b0);
         maybe_idle();
      end
      req_push <= 1'b0;

      while (pending_verdicts.size() != 0)
         @(posedge clock);
      repeat (200) @(posedge clock);
      if (mismatch_count == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

   // hard stop: every item at its worst latency, several times over
   initial begin
      #(64'd12 * 64'd300 * DRAIN_CYCLES * 64'd4);
      $display("TB_ERROR");
      $finish;
   end

endmodule
`default_nettype wire
